FILE: hdl/smmu_pkg.sv
// shared types and constants for the segmented mmu
`default_nettype none
package smmu_pkg;
   localparam logic [1:0] OP_XLATE = 2'd0;
   localparam logic [1:0] OP_CRD = 2'd1;
   localparam logic [1:0] OP_CWR = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [7:0] AT_RD = 8'h01;
   localparam logic [7:0] AT_SYS = 8'h02;
   localparam logic [7:0] AT_CPUI = 8'h04;
   localparam logic [7:0] AT_EXC = 8'h08;
   localparam logic [7:0] AT_DMAI = 8'h10;
   localparam logic [7:0] AT_DIRW = 8'h20;
   localparam logic [7:0] AT_CHG = 8'h40;
   localparam logic [7:0] AT_REF = 8'h80;

   localparam logic [7:0] MD_MSEN = 8'h80;
   localparam logic [7:0] MD_TRNS = 8'h40;
   localparam logic [7:0] MD_URS = 8'h20;

   localparam logic [7:0] VK_FATL = 8'h80;
   localparam logic [7:0] VK_SWW = 8'h40;
   localparam logic [7:0] VK_PWW = 8'h20;
   localparam logic [7:0] VK_EXCV = 8'h10;
   localparam logic [7:0] VK_CPUIV = 8'h08;
   localparam logic [7:0] VK_SLV = 8'h04;
   localparam logic [7:0] VK_SYSV = 8'h02;
   localparam logic [7:0] VK_RDV = 8'h01;

   localparam logic [3:0] ST_FETCH = 4'hD;
   localparam logic [3:0] ST_WRITE = 4'hA;
   localparam logic [3:0] ST_READ = 4'h9;

   localparam logic [7:0] CMD_MODE = 8'h00;
   localparam logic [7:0] CMD_SAR = 8'h01;
   localparam logic [7:0] CMD_KIND = 8'h02;
   localparam logic [7:0] CMD_VSEG = 8'h03;
   localparam logic [7:0] CMD_VOFF = 8'h04;
   localparam logic [7:0] CMD_BSTAT = 8'h05;
   localparam logic [7:0] CMD_BASE = 8'h08;
   localparam logic [7:0] CMD_LIM = 8'h09;
   localparam logic [7:0] CMD_ATTR = 8'h0A;
   localparam logic [7:0] CMD_DESC = 8'h0B;
   localparam logic [7:0] CMD_BASE_I = 8'h0C;
   localparam logic [7:0] CMD_LIM_I = 8'h0D;
   localparam logic [7:0] CMD_ATTR_I = 8'h0E;
   localparam logic [7:0] CMD_DESC_I = 8'h0F;
   localparam logic [7:0] CMD_CLRV = 8'h11;
   localparam logic [7:0] CMD_CLRSWW = 8'h13;
   localparam logic [7:0] CMD_CLRFATL = 8'h14;
   localparam logic [7:0] CMD_SETCPUI = 8'h15;
   localparam logic [7:0] CMD_SETDMAI = 8'h16;
   localparam logic [7:0] CMD_DSC = 8'h20;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] seg_num;
      logic [15:0] offset;
      logic write_acc;
      logic user_mode;
      logic fetch_acc;
      logic [7:0] cmd;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [23:0] phys_addr;
      logic fault;
      logic [7:0] read_data;
      logic seg_trap;
   } rsp_type;
endpackage
`default_nettype wire

FILE: hdl/smmu_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module smmu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/segmented_mmu_translate_protect_top.sv
// segmented mmu top level: descriptor ram, sequencer and violation registers
//  channel | direction | payload          | handshake
//  req     | in        | smmu_pkg::req_type | req_valid / req_stall
//  rsp     | out       | smmu_pkg::rsp_type | rsp_valid / rsp_stall
// an item passes through accept, descriptor read, execute and write back, then result
// the result is registered at the end of execute and is valid in the result state
// bulk inhibit commands walk the table, reading and then writing back each entry
// after reset the table is cleared one entry per cycle, with req_stall high until done
// the result is held in an output register while rsp_stall is high
`default_nettype none
module segmented_mmu_translate_protect_top #(
   parameter int NUM_SEGMENTS = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire smmu_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output smmu_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(NUM_SEGMENTS);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_BULK_RD, S_BULK_WR, S_OUT}
      state_type;

   state_type state_ff;
   smmu_pkg::req_type req_ff;
   logic [AW-1:0] idx_ff;
   logic [7:0] mode_ff;
   logic [5:0] sar_ff;
   logic [1:0] dsc_ff;
   logic [7:0] vkind_ff;
   logic [6:0] vseg_ff;
   logic [15:0] voff_ff;
   logic [5:0] bstat_ff;
   logic capt_ff, trap_ff, warn_ff;
   smmu_pkg::rsp_type rsp_ff;
   smmu_pkg::rsp_type rsp_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_word, rd_word;

   smmu_ram #(.WIDTH(32), .DEPTH(NUM_SEGMENTS)) u_desc (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_word),
      .rd_addr(rd_addr), .rd_data(rd_word)
   );

   // descriptor number modulo table size by up to four compare and subtract steps (exact while n < 5*NUM_SEGMENTS)
   function automatic logic [AW-1:0] to_idx(input logic [5:0] n);
      logic [6:0] v;
      v = {1'b0, n};
      for (int k = 0; k < 4; k++)
         if (v >= 7'(NUM_SEGMENTS)) v = v - 7'(NUM_SEGMENTS);
      return v[AW-1:0];
   endfunction

   logic [AW-1:0] item_idx;
   assign item_idx = (req_ff.op == smmu_pkg::OP_XLATE) ? to_idx(req_ff.seg_num[5:0])
                                                       : to_idx(sar_ff);
   always_comb begin
      rd_addr = item_idx;
      if (state_ff == S_BULK_RD || state_ff == S_BULK_WR) rd_addr = idx_ff;
   end

   logic [15:0] d_base;
   logic [7:0] d_lim, d_attr;
   assign d_base = rd_word[31:16];
   assign d_lim = rd_word[15:8];
   assign d_attr = rd_word[7:0];

   // translate decode
   logic [7:0] page;
   logic untrans;
   logic [7:0] hkind;
   logic [7:0] nattr;
   logic pww;
   logic [3:0] st;
   assign page = req_ff.offset[15:8];
   assign untrans = !(mode_ff[7] && mode_ff[6]) || (req_ff.seg_num[6] != mode_ff[5]);
   assign st = req_ff.fetch_acc ? smmu_pkg::ST_FETCH
             : (req_ff.write_acc ? smmu_pkg::ST_WRITE : smmu_pkg::ST_READ);
   always_comb begin
      priority if ((d_attr & smmu_pkg::AT_CPUI) != 0) hkind = smmu_pkg::VK_CPUIV;
      else if ((d_attr & smmu_pkg::AT_DIRW) != 0 ? page < d_lim : page > d_lim)
         hkind = smmu_pkg::VK_SLV;
      else if ((d_attr & smmu_pkg::AT_RD) != 0 && req_ff.write_acc) hkind = smmu_pkg::VK_RDV;
      else if ((d_attr & smmu_pkg::AT_SYS) != 0 && req_ff.user_mode)
         hkind = smmu_pkg::VK_SYSV;
      else if ((d_attr & smmu_pkg::AT_EXC) != 0 && !req_ff.fetch_acc)
         hkind = smmu_pkg::VK_EXCV;
      else hkind = 8'd0;
   end
   assign nattr = d_attr | smmu_pkg::AT_REF | (req_ff.write_acc ? smmu_pkg::AT_CHG : 8'd0);
   assign pww = (d_attr & smmu_pkg::AT_DIRW) != 0 && req_ff.write_acc && page == d_lim;

   // field access decode
   logic is_field;
   logic [1:0] which;
   logic [7:0] fbyte;
   logic [31:0] fword;
   logic [5:0] sar_n;
   logic [1:0] dsc_n;
   always_comb begin
      is_field = req_ff.cmd[7:3] == 5'b00001;
      unique case (req_ff.cmd[1:0])
         2'd0: which = {1'b0, dsc_ff[0]};
         2'd1: which = 2'd2;
         2'd2: which = 2'd3;
         default: which = dsc_ff;
      endcase
      unique case (which)
         2'd0: fbyte = d_base[15:8];
         2'd1: fbyte = d_base[7:0];
         2'd2: fbyte = d_lim;
         default: fbyte = d_attr;
      endcase
      fword = rd_word;
      unique case (which)
         2'd0: fword[31:24] = req_ff.data;
         2'd1: fword[23:16] = req_ff.data;
         2'd2: fword[15:8] = req_ff.data;
         default: fword[7:0] = req_ff.data;
      endcase
      sar_n = sar_ff;
      dsc_n = dsc_ff;
      unique case (req_ff.cmd[1:0])
         2'd0: begin
            dsc_n = dsc_ff[0] ? 2'd0 : 2'd1;
            if (dsc_ff[0] && req_ff.cmd[2]) sar_n = sar_ff + 6'd1;
         end
         2'd3: begin
            dsc_n = dsc_ff + 2'd1;
            if (dsc_ff == 2'd3 && req_ff.cmd[2]) sar_n = sar_ff + 6'd1;
         end
         default: if (req_ff.cmd[2]) sar_n = sar_ff + 6'd1;
      endcase
   end

   // violation latch
   logic viol, vhard;
   logic [7:0] vk_in, kind;
   logic fatal, sww;
   always_comb begin
      vhard = hkind != 0;
      viol = state_ff == S_EXEC && req_ff.op == smmu_pkg::OP_XLATE && !untrans
             && (vhard || pww);
      kind = vhard ? hkind : smmu_pkg::VK_PWW;
      fatal = capt_ff && (vhard || req_ff.user_mode);
      sww = !vhard && !req_ff.user_mode && (vkind_ff & smmu_pkg::VK_PWW) != 0 && !fatal;
      vk_in = (capt_ff ? (vkind_ff | kind) : kind)
              | (fatal ? smmu_pkg::VK_FATL : 8'd0) | (sww ? smmu_pkg::VK_SWW : 8'd0);
   end

   logic [7:0] crd;
   always_comb begin
      unique case (req_ff.cmd)
         smmu_pkg::CMD_MODE: crd = mode_ff;
         smmu_pkg::CMD_SAR: crd = {2'd0, sar_ff};
         smmu_pkg::CMD_DSC: crd = {6'd0, dsc_ff};
         smmu_pkg::CMD_KIND: crd = vkind_ff;
         smmu_pkg::CMD_VSEG: crd = {1'b0, vseg_ff};
         smmu_pkg::CMD_VOFF: crd = voff_ff[15:8];
         smmu_pkg::CMD_BSTAT: crd = {2'd0, bstat_ff};
         default: crd = is_field ? fbyte : 8'd0;
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = item_idx;
      wr_word = rd_word;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff;
            wr_word = 32'd0;
         end
         S_BULK_WR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff;
            wr_word = {rd_word[31:8], rd_word[7:0] |
               (req_ff.cmd == smmu_pkg::CMD_SETCPUI ? smmu_pkg::AT_CPUI : smmu_pkg::AT_DMAI)};
         end
         S_EXEC: begin
            if (req_ff.op == smmu_pkg::OP_XLATE) begin
               wr_en = !untrans && !vhard;
               wr_word = {rd_word[31:8], nattr};
            end else if (req_ff.op == smmu_pkg::OP_CWR) begin
               wr_en = is_field;
               wr_word = fword;
            end
         end
         default: ;
      endcase
   end

   logic [23:0] ident;
   assign ident = {1'b0, req_ff.seg_num, req_ff.offset};

   // result of the item in execute
   always_comb begin
      rsp_in = '0;
      rsp_in.seg_trap = trap_ff;
      unique case (req_ff.op)
         smmu_pkg::OP_XLATE: begin
            rsp_in.phys_addr = (untrans || vhard) ? ident
               : ({d_base, 8'd0} + {8'd0, req_ff.offset});
            rsp_in.fault = !untrans && vhard;
            if (viol && (vk_in & (smmu_pkg::VK_FATL | smmu_pkg::VK_SWW)) == 8'd0)
               rsp_in.seg_trap = 1'b1;
         end
         smmu_pkg::OP_CRD: rsp_in.read_data = crd;
         smmu_pkg::OP_CWR: if (req_ff.cmd == smmu_pkg::CMD_CLRV) rsp_in.seg_trap = 1'b0;
         default: ;
      endcase
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         mode_ff <= smmu_pkg::MD_MSEN;
         sar_ff <= '0;
         dsc_ff <= '0;
         vkind_ff <= '0;
         vseg_ff <= '0;
         voff_ff <= '0;
         bstat_ff <= '0;
         capt_ff <= 1'b0;
         trap_ff <= 1'b0;
         warn_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == AW'(NUM_SEGMENTS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid) begin
               req_ff <= req_data;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_EXEC;
            S_BULK_RD: state_ff <= S_BULK_WR;
            S_BULK_WR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == AW'(NUM_SEGMENTS - 1)) begin
                  rsp_ff <= '{phys_addr: 24'd0, fault: 1'b0, read_data: 8'd0,
                              seg_trap: trap_ff};
                  state_ff <= S_OUT;
               end else state_ff <= S_BULK_RD;
            end
            S_EXEC: begin
               state_ff <= S_OUT;
               rsp_ff <= rsp_in;
               unique case (req_ff.op)
                  smmu_pkg::OP_XLATE: begin
                     if (viol) begin
                        vkind_ff <= vk_in;
                        if (!capt_ff) begin
                           vseg_ff <= req_ff.seg_num;
                           voff_ff <= req_ff.offset;
                           bstat_ff <= {req_ff.user_mode, req_ff.write_acc, st};
                           capt_ff <= 1'b1;
                        end
                        if ((vk_in & (smmu_pkg::VK_FATL | smmu_pkg::VK_SWW)) == 0) begin
                           trap_ff <= 1'b1;
                           if (!vhard) warn_ff <= 1'b1;
                        end
                     end
                  end
                  smmu_pkg::OP_CRD: begin
                     if (is_field) begin
                        sar_ff <= sar_n;
                        dsc_ff <= dsc_n;
                     end
                  end
                  smmu_pkg::OP_CWR: begin
                     if (is_field) begin
                        sar_ff <= sar_n;
                        dsc_ff <= dsc_n;
                     end
                     unique case (req_ff.cmd)
                        smmu_pkg::CMD_MODE: mode_ff <= req_ff.data;
                        smmu_pkg::CMD_SAR: begin
                           sar_ff <= req_ff.data[5:0];
                           dsc_ff <= 2'd0;
                        end
                        smmu_pkg::CMD_DSC: dsc_ff <= req_ff.data[1:0];
                        smmu_pkg::CMD_CLRV: begin
                           vkind_ff <= 8'd0;
                           capt_ff <= 1'b0;
                           trap_ff <= 1'b0;
                        end
                        smmu_pkg::CMD_CLRSWW: vkind_ff <= vkind_ff & ~smmu_pkg::VK_SWW;
                        smmu_pkg::CMD_CLRFATL: vkind_ff <= vkind_ff & ~smmu_pkg::VK_FATL;
                        smmu_pkg::CMD_SETCPUI, smmu_pkg::CMD_SETDMAI: begin
                           idx_ff <= '0;
                           state_ff <= S_BULK_RD;
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
